>>> src/csvs_pkg.sv
// ----------------------------------------------------------------------------
// csvs_pkg
// Types, byte codes and helpers shared by the CSV field splitter files.
// ----------------------------------------------------------------------------
package csvs_pkg;

   localparam int FIELD_LEN   = 63;
   localparam int MAX_COLUMNS = 32;
   localparam int PEND_DEPTH  = 63;

   localparam int CHAR_W  = 8;
   localparam int COL_W   = 5;
   localparam int CNT_W   = 6;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILDE_AS_QUOTE = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd18;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;

   localparam logic [KIND_W-1:0] KIND_SPACE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TAB   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VT    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FF    = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } csvs_state_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [CHAR_W-1:0] char_out;
      logic              char_valid;
      logic              field_end;
      logic              line_end;
      logic              last;
   } csvs_rsp_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic [KIND_W-1:0] space_kind(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         CH_TAB:  k = KIND_TAB;
         CH_VT:   k = KIND_VT;
         CH_FF:   k = KIND_FF;
         default: k = KIND_SPACE;
      endcase
      return k;
   endfunction

   function automatic logic [CHAR_W-1:0] kind_byte(input logic [KIND_W-1:0] k);
      logic [CHAR_W-1:0] b;
      case (k)
         KIND_TAB: b = CH_TAB;
         KIND_VT:  b = CH_VT;
         KIND_FF:  b = CH_FF;
         default:  b = CH_SPACE;
      endcase
      return b;
   endfunction

endpackage

>>> src/csvs_if.sv
// ----------------------------------------------------------------------------
// csvs_req_if / csvs_rsp_if
// Valid/ready channels for line bytes in and field results out.
// ----------------------------------------------------------------------------
interface csvs_req_if;
   logic                       valid;
   logic                       ready;
   logic [csvs_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface csvs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csvs_pkg::COL_W-1:0]  column;
   logic [csvs_pkg::CHAR_W-1:0] char_out;
   logic                        char_valid;
   logic                        field_end;
   logic                        line_end;
   logic                        last;

   modport source (output valid, output column, output char_out, output char_valid,
                   output field_end, output line_end, output last, input ready);
   modport sink   (input valid, input column, input char_out, input char_valid,
                   input field_end, input line_end, input last, output ready);
endinterface

>>> src/csv_field_splitter_trim.sv
// A result is on rsp in the cycle after its byte is taken; held whitespace and the
// text byte releasing it go out via ST_DRAIN and the output register. One byte per
// cycle while rsp is not stalled and no drain runs; a text byte after held whitespace
// blocks the input until the held bytes, read from the hold memory, and the text byte
// have gone out. Reset (synchronous, active high) clears the line state and rsp valid
// and loads column_limit 18 and tilde_as_quote 1; the hold memory is not cleared.
// ----------------------------------------------------------------------------
// csv_field_splitter_trim
// Splits a byte stream into trimmed, quote-aware CSV fields, one result at a time.
// ----------------------------------------------------------------------------
module csv_field_splitter_trim (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [csvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csvs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   csvs_req_if.sink                          req,
   csvs_rsp_if.source                        rsp
);
   import csvs_pkg::*;

   csvs_state_type state_ff, state_in;

   logic [LIMIT_W-1:0] column_limit_ff;
   logic               tilde_as_quote_ff;

   logic               in_quotes_ff, in_quotes_in;
   logic [COL_W-1:0]   field_index_ff, field_index_in;
   logic [CNT_W-1:0]   raw_count_ff, raw_count_in;
   logic               text_seen_ff, text_seen_in;
   logic [CNT_W-1:0]   pend_count_ff, pend_count_in;
   logic               line_closed_ff, line_closed_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CHAR_W-1:0]  hold_char_ff, hold_char_in;

   logic               rsp_valid_ff, rsp_valid_in;
   csvs_rsp_type       rsp_data_ff, rsp_data_in;

   logic [KIND_W-1:0]  kind_mem [0:PEND_DEPTH-1];
   logic [KIND_W-1:0]  rd_kind_ff;
   logic               mem_we;
   logic [KIND_W-1:0]  mem_wkind;

   logic               slot_free;
   logic               accept;
   logic               start_drain;
   logic               drain_done;
   logic [LIMIT_W-1:0] lim;
   logic [CHAR_W-1:0]  c;
   logic               is_eol;
   logic               is_quote;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign c         = req.char_in;
   assign is_eol    = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
   assign is_quote  = (c == CH_QUOTE) || ((c == CH_TILDE) && tilde_as_quote_ff);
   assign drain_done = slot_free && (rd_idx_ff == pend_count_ff);

   always_comb begin
      if (column_limit_ff == '0) begin
         lim = LIMIT_W'(1);
      end else if (column_limit_ff > LIMIT_W'(MAX_COLUMNS)) begin
         lim = LIMIT_W'(MAX_COLUMNS);
      end else begin
         lim = column_limit_ff;
      end
   end

   assign start_drain = accept && !is_eol && !line_closed_ff && !is_quote
                        && !((c == CH_COMMA) && !in_quotes_ff)
                        && (raw_count_ff < CNT_W'(FIELD_LEN))
                        && !is_space(c) && (pend_count_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_drain) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      in_quotes_in   = in_quotes_ff;
      field_index_in = field_index_ff;
      raw_count_in   = raw_count_ff;
      text_seen_in   = text_seen_ff;
      pend_count_in  = pend_count_ff;
      line_closed_in = line_closed_ff;
      rd_idx_in      = rd_idx_ff;
      hold_char_in   = hold_char_ff;
      mem_we         = 1'b0;
      mem_wkind      = space_kind(c);
      req.ready      = 1'b0;
      rsp_valid_in   = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            req.ready = slot_free;
            if (req.valid && slot_free) begin
               rsp_data_in = '{column: field_index_ff, char_out: '0, char_valid: 1'b0,
                               field_end: 1'b1, line_end: 1'b1, last: 1'b1};
               if (is_eol) begin
                  rsp_valid_in   = !line_closed_ff;
                  raw_count_in   = '0;
                  text_seen_in   = 1'b0;
                  pend_count_in  = '0;
                  in_quotes_in   = 1'b0;
                  field_index_in = '0;
                  line_closed_in = 1'b0;
               end else if (line_closed_ff) begin
                  rsp_valid_in = 1'b0;
               end else if (is_quote) begin
                  in_quotes_in = !in_quotes_ff;
               end else if ((c == CH_COMMA) && !in_quotes_ff) begin
                  rsp_valid_in = 1'b1;
                  raw_count_in  = '0;
                  text_seen_in  = 1'b0;
                  pend_count_in = '0;
                  if ((LIMIT_W'(field_index_ff) + LIMIT_W'(1)) >= lim) begin
                     field_index_in = '0;
                     line_closed_in = 1'b1;
                  end else begin
                     rsp_data_in.line_end = 1'b0;
                     field_index_in = field_index_ff + COL_W'(1);
                  end
               end else if (raw_count_ff < CNT_W'(FIELD_LEN)) begin
                  raw_count_in = raw_count_ff + CNT_W'(1);
                  if (is_space(c)) begin
                     if (text_seen_ff && (pend_count_ff < CNT_W'(PEND_DEPTH))) begin
                        mem_we        = 1'b1;
                        pend_count_in = pend_count_ff + CNT_W'(1);
                     end
                  end else if (pend_count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{column: field_index_ff, char_out: c, char_valid: 1'b1,
                                      field_end: 1'b0, line_end: 1'b0, last: 1'b1};
                     text_seen_in = 1'b1;
                  end else begin
                     hold_char_in = c;
                     rd_idx_in    = '0;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (rd_idx_ff != pend_count_ff) begin
                  rsp_data_in = '{column: field_index_ff, char_out: kind_byte(rd_kind_ff),
                                  char_valid: 1'b1, field_end: 1'b0, line_end: 1'b0,
                                  last: 1'b0};
                  rd_idx_in   = rd_idx_ff + CNT_W'(1);
               end else begin
                  rsp_data_in = '{column: field_index_ff, char_out: hold_char_ff,
                                  char_valid: 1'b1, field_end: 1'b0, line_end: 1'b0,
                                  last: 1'b1};
                  pend_count_in = '0;
                  text_seen_in  = 1'b1;
                  rd_idx_in     = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // hold memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[pend_count_ff] <= mem_wkind;
      end
      if (rd_idx_in < CNT_W'(PEND_DEPTH)) begin
         rd_kind_ff <= kind_mem[rd_idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         column_limit_ff   <= LIMIT_RESET;
         tilde_as_quote_ff <= 1'b1;
         in_quotes_ff      <= 1'b0;
         field_index_ff    <= '0;
         raw_count_ff      <= '0;
         text_seen_ff      <= 1'b0;
         pend_count_ff     <= '0;
         line_closed_ff    <= 1'b0;
         rd_idx_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_quotes_ff   <= in_quotes_in;
         field_index_ff <= field_index_in;
         raw_count_ff   <= raw_count_in;
         text_seen_ff   <= text_seen_in;
         pend_count_ff  <= pend_count_in;
         line_closed_ff <= line_closed_in;
         rd_idx_ff      <= rd_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMN_LIMIT:   column_limit_ff   <= csr_wdata[LIMIT_W-1:0];
               CSR_TILDE_AS_QUOTE: tilde_as_quote_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_char_ff <= hold_char_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.column     = rsp_data_ff.column;
   assign rsp.char_out   = rsp_data_ff.char_out;
   assign rsp.char_valid = rsp_data_ff.char_valid;
   assign rsp.field_end  = rsp_data_ff.field_end;
   assign rsp.line_end   = rsp_data_ff.line_end;
   assign rsp.last       = rsp_data_ff.last;

   a_drain_has_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (pend_count_ff != '0) && (rd_idx_ff <= pend_count_ff))
      else $error("drain without held whitespace");

   a_idle_read_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (rd_idx_ff == '0))
      else $error("read pointer not parked in idle");

   a_closed_line_index: assert property (@(posedge clock) disable iff (reset)
      line_closed_ff |-> (field_index_ff == '0) && (pend_count_ff == '0))
      else $error("closed line keeps field state");

   a_raw_bound: assert property (@(posedge clock) disable iff (reset)
      (raw_count_ff <= CNT_W'(FIELD_LEN)) && (pend_count_ff <= raw_count_ff))
      else $error("field byte counts out of range");

   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      start_drain |=> !req.ready)
      else $error("input taken while draining");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for csv_field_splitter_trim. Line bytes go in over the
// req channel while a scoreboard predicts the trimmed field results and checks
// every rsp transaction. Phases step through column limits, tilde handling,
// and the sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
package csvs_tb_pkg;
   import csvs_pkg::*;

   class field_scoreboard;
      logic [LIMIT_W-1:0] column_limit;
      logic               tilde_as_quote;
      logic               in_quotes;
      logic [COL_W-1:0]   field_idx;
      logic [CNT_W-1:0]   raw_cnt;
      logic               text_seen;
      logic [CNT_W-1:0]   held_cnt;
      logic [KIND_W-1:0]  held_kind [PEND_DEPTH];
      logic               line_closed;
      csvs_rsp_type       field_results_q [$];
      int                 errors;

      function new();
         column_limit   = LIMIT_RESET;
         tilde_as_quote = 1'b1;
         errors         = 0;
         start_line();
      endfunction

      function void start_field();
         raw_cnt   = '0;
         text_seen = 1'b0;
         held_cnt  = '0;
      endfunction

      function void start_line();
         start_field();
         in_quotes   = 1'b0;
         field_idx   = '0;
         line_closed = 1'b0;
      endfunction

      function int ws_code(logic [CHAR_W-1:0] c);
         if (c == CH_SPACE) return int'(KIND_SPACE);
         if (c == CH_TAB) return int'(KIND_TAB);
         if (c == CH_VT) return int'(KIND_VT);
         if (c == CH_FF) return int'(KIND_FF);
         return -1;
      endfunction

      function logic [CHAR_W-1:0] ws_char(logic [KIND_W-1:0] k);
         logic [CHAR_W-1:0] b;
         case (k)
            KIND_TAB: b = CH_TAB;
            KIND_VT:  b = CH_VT;
            KIND_FF:  b = CH_FF;
            default:  b = CH_SPACE;
         endcase
         return b;
      endfunction

      function void add_result(logic [CHAR_W-1:0] ch, logic cv, logic fe, logic le);
         csvs_rsp_type r;
         r.column     = field_idx;
         r.char_out   = ch;
         r.char_valid = cv;
         r.field_end  = fe;
         r.line_end   = le;
         r.last       = 1'b0;
         field_results_q.push_back(r);
      endfunction

      // predicts the results caused by one accepted byte
      function void note_byte(logic [CHAR_W-1:0] c);
         int lim;
         int k;
         int n0;
         logic closes;
         csvs_rsp_type r;
         lim = int'(column_limit);
         if (lim == 0) lim = 1;
         if (lim > MAX_COLUMNS) lim = MAX_COLUMNS;
         n0 = field_results_q.size();
         if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
            if (!line_closed) add_result('0, 1'b0, 1'b1, 1'b1);
            start_line();
         end else if (line_closed) begin
         end else if (c == CH_QUOTE || (c == CH_TILDE && tilde_as_quote)) begin
            in_quotes = !in_quotes;
         end else if (c == CH_COMMA && !in_quotes) begin
            closes = (int'(field_idx) + 1) >= lim;
            add_result('0, 1'b0, 1'b1, closes);
            start_field();
            if (closes) begin
               field_idx   = '0;
               line_closed = 1'b1;
            end else begin
               field_idx = field_idx + 1'b1;
            end
         end else if (raw_cnt < FIELD_LEN) begin
            raw_cnt = raw_cnt + 1'b1;
            k = ws_code(c);
            if (k >= 0) begin
               if (text_seen && held_cnt < PEND_DEPTH) begin
                  held_kind[held_cnt] = k[KIND_W-1:0];
                  held_cnt = held_cnt + 1'b1;
               end
            end else begin
               for (int i = 0; i < held_cnt; i++)
                  add_result(ws_char(held_kind[i]), 1'b1, 1'b0, 1'b0);
               held_cnt = '0;
               add_result(c, 1'b1, 1'b0, 1'b0);
               text_seen = 1'b1;
            end
         end
         if (field_results_q.size() > n0) begin
            r = field_results_q.pop_back();
            r.last = 1'b1;
            field_results_q.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [7:0] e, logic [7:0] a);
         if (a !== e) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(csvs_rsp_type got);
         csvs_rsp_type e;
         if (field_results_q.size() == 0) begin
            $error("unexpected result: column %0d char_out %0h valid %0b fend %0b lend %0b",
                   got.column, got.char_out, got.char_valid, got.field_end, got.line_end);
            errors++;
            return;
         end
         e = field_results_q.pop_front();
         compare_field("column", 8'(e.column), 8'(got.column));
         compare_field("char_out", e.char_out, got.char_out);
         compare_field("char_valid", 8'(e.char_valid), 8'(got.char_valid));
         compare_field("field_end", 8'(e.field_end), 8'(got.field_end));
         compare_field("line_end", 8'(e.line_end), 8'(got.line_end));
         compare_field("last", 8'(e.last), 8'(got.last));
      endfunction
   endclass
endpackage

module tb_top;
   import csvs_pkg::*;
   import csvs_tb_pkg::*;

   localparam int QUIET_LIMIT = 5000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   csvs_req_if req_if ();
   csvs_rsp_if rsp_if ();

   csv_field_splitter_trim uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_if),
      .rsp       (rsp_if)
   );

   field_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(negedge clock) begin
      csvs_rsp_type r;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            r.column     = rsp_if.column;
            r.char_out   = rsp_if.char_out;
            r.char_valid = rsp_if.char_valid;
            r.field_end  = rsp_if.field_end;
            r.line_end   = rsp_if.line_end;
            r.last       = rsp_if.last;
            sb.check_result(r);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [CHAR_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.char_in <= b;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.field_results_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic configure(input int limit, input int tilde);
      write_reg(CSR_COLUMN_LIMIT, limit);
      write_reg(CSR_TILDE_AS_QUOTE, tilde);
      csr_we <= 1'b0;
      sb.column_limit   = limit[LIMIT_W-1:0];
      sb.tilde_as_quote = tilde[0];
   endtask

   function automatic logic [CHAR_W-1:0] rand_ws();
      logic [CHAR_W-1:0] b;
      case ($urandom_range(3))
         0:       b = CH_TAB;
         1:       b = CH_VT;
         2:       b = CH_FF;
         default: b = CH_SPACE;
      endcase
      return b;
   endfunction

   // non-whitespace byte that does not end the line
   function automatic logic [CHAR_W-1:0] rand_text();
      logic [CHAR_W-1:0] c;
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(33, 126));
      if (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB ||
          c == CH_VT || c == CH_FF)
         c = c | 8'h80;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_eol();
      logic [CHAR_W-1:0] b;
      case ($urandom_range(2))
         0:       b = CH_NUL;
         1:       b = CH_CR;
         default: b = CH_LF;
      endcase
      return b;
   endfunction

   // shape: 0 mixed fields, 1 first field over-long, 2 many tiny fields
   task automatic send_line(input int nfields, input int shape);
      int nseg;
      logic [CHAR_W-1:0] q;
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) send_byte(CH_COMMA);
         if (shape == 1 && f == 0) begin
            send_byte(rand_text());
            repeat (61) send_byte(rand_ws());
            send_byte(rand_text());
            repeat (4) send_byte(rand_text());
            send_byte(CH_QUOTE);
            send_byte(CH_COMMA);
            send_byte(CH_QUOTE);
         end else if (shape == 2) begin
            if ($urandom_range(3) == 0) send_byte(rand_text());
         end else begin
            repeat ($urandom_range(2)) send_byte(rand_ws());
            nseg = $urandom_range(3);
            for (int s = 0; s < nseg; s++) begin
               case ($urandom_range(5))
                  0: begin
                     q = $urandom_range(1) ? CH_QUOTE : CH_TILDE;
                     send_byte(q);
                     repeat ($urandom_range(1, 3))
                        send_byte($urandom_range(2) == 0 ? CH_COMMA : rand_text());
                     send_byte(q);
                  end
                  1: repeat ($urandom_range(1, 3)) send_byte(rand_ws());
                  default: repeat ($urandom_range(1, 4)) send_byte(rand_text());
               endcase
            end
            repeat ($urandom_range(2)) send_byte(rand_ws());
         end
      end
      if ($urandom_range(7) == 0) send_byte(CH_QUOTE);
      send_byte(rand_eol());
   endtask

   task automatic send_noise();
      repeat ($urandom_range(3, 12)) send_byte(8'($urandom_range(255)));
      send_byte(CH_LF);
   endtask

   task automatic send_directed();
      send_byte(CH_LF);
      send_byte(CH_SPACE);
      send_byte(CH_TAB);
      send_byte(CH_VT);
      send_byte(CH_FF);
      send_byte(8'hFF);
      send_byte(CH_SPACE);
      send_byte(CH_TAB);
      send_byte(8'h7F);
      send_byte(CH_FF);
      send_byte(CH_COMMA);
      send_byte(CH_QUOTE);
      send_byte(8'h41);
      send_byte(CH_COMMA);
      send_byte(CH_TILDE);
      send_byte(CH_COMMA);
      send_byte(8'h01);
      send_byte(CH_CR);
      send_byte(CH_QUOTE);
      send_byte(8'h42);
      send_byte(CH_NUL);
   endtask

   initial begin
      int limits [6] = '{18, 1, 32, 0, 63, 3};
      int tildes [6] = '{1, 0, 1, 1, 0, 1};
      int idles  [6] = '{0, 66, 0, 33, 0, 33};
      int stalls [6] = '{0, 0, 66, 33, 0, 66};
      int target;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_COLUMN_LIMIT;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.char_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            drain_results();
            repeat (4) @(posedge clock);
         end
         configure(limits[p], (p == 5) ? $urandom_range(1) : tildes[p]);
         send_idle_pct = idles[p];
         stall_pct     = stalls[p];
         target = bytes_sent + 10;
         if (p == 0) send_directed();
         if (p == 2) send_line(2, 1);
         if (p == 4) send_line(33, 2);
         while (bytes_sent < target) begin
            if ($urandom_range(5) == 0) send_noise();
            else send_line($urandom_range(1, 3), 0);
            if ($urandom_range(3) == 0) drain_results();
         end
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.field_results_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
